@@ hdl/cfr_pkg.sv @@
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types and constants for the command frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

  // Longest payload a length byte may announce
  localparam int unsigned MaxPayload = 16;
  localparam logic [5:0]  MaxLen     = 6'(MaxPayload);

  // Frame characters
  localparam logic [7:0] StartChar = 8'h3A;  // ':'
  localparam logic [7:0] TermChar  = 8'h0D;  // carriage return

  // Frame holds payload length plus this many bytes
  localparam logic [5:0] FrameOverhead = 6'd7;
  // Last index the byte counter can reach
  localparam logic [4:0] LastPos = 5'd31;

  typedef enum logic [2:0] {
    StReceiving = 3'd0,
    StOk        = 3'd1,
    StLenErr    = 3'd2,
    StTermErr   = 3'd3,
    StSumErr    = 3'd4
  } status_e;

  typedef enum logic {
    CmdData  = 1'b0,
    CmdClear = 1'b1
  } cmd_e;

  // One result item
  typedef struct packed {
    logic       stored;
    logic [4:0] position;
    logic [7:0] stored_byte;
    status_e    frame_status;
  } result_t;

endpackage

@@ hdl/cfr_in_if.sv @@
// ----------------------------------------------------------------------------
// cfr_in_if
// Request channel into the receiver: command and raw byte.
// ----------------------------------------------------------------------------
interface cfr_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

@@ hdl/cfr_out_if.sv @@
// ----------------------------------------------------------------------------
// cfr_out_if
// Result channel out of the receiver: stored byte info and frame status.
// ----------------------------------------------------------------------------
interface cfr_out_if;
  logic       valid;
  logic       ready;
  logic       stored;
  logic [4:0] position;
  logic [7:0] stored_byte;
  logic [2:0] frame_status;

  modport source (output valid, output stored, output position, output stored_byte,
                  output frame_status, input ready);
  modport sink   (input valid, input stored, input position, input stored_byte,
                  input frame_status, output ready);
endinterface

@@ hdl/cfr_parser.sv @@
// ----------------------------------------------------------------------------
// cfr_parser
// Frame state (count, length, sum, status) and the per-request result.
// ----------------------------------------------------------------------------
module cfr_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              cmd_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              checksum_en_i,
  output cfr_pkg::result_t  result_o
);
  import cfr_pkg::*;

  logic [4:0] count_q, count_d;
  logic [4:0] len_q, len_d;
  logic [7:0] sum_q, sum_d;
  status_e    status_q, status_d;

  logic [5:0] target;
  logic       last_byte;

  assign target    = {1'b0, len_q} + FrameOverhead;
  assign last_byte = (({1'b0, count_q} + 6'd1) >= target) || (count_q == LastPos);

  // Next state and result for one request
  always_comb begin
    count_d  = count_q;
    len_d    = len_q;
    sum_d    = sum_q;
    status_d = status_q;
    result_o = '0;

    if (cmd_i == CmdClear) begin
      count_d  = '0;
      len_d    = '0;
      sum_d    = '0;
      status_d = StReceiving;
    end else if (status_q == StReceiving) begin
      if (count_q == 5'd0) begin
        // hunt for start character
        if (rx_byte_i == StartChar) begin
          result_o.stored = 1'b1;
          count_d         = 5'd1;
          sum_d           = '0;
        end
      end else if (count_q == 5'd1) begin
        // length byte
        if ({1'b0, rx_byte_i[4:0]} <= MaxLen) begin
          result_o.stored   = 1'b1;
          result_o.position = 5'd1;
          len_d             = rx_byte_i[4:0];
          sum_d             = rx_byte_i;
          count_d           = 5'd2;
        end else begin
          status_d = StLenErr;
        end
      end else begin
        result_o.stored   = 1'b1;
        result_o.position = count_q;
        count_d           = count_q + 5'd1;
        if (last_byte) begin
          if (rx_byte_i != TermChar) begin
            status_d = StTermErr;
          end else if (checksum_en_i && (sum_q != 8'd0)) begin
            status_d = StSumErr;
          end else begin
            status_d = StOk;
          end
        end else begin
          sum_d = sum_q + rx_byte_i;
        end
      end
    end

    if (result_o.stored) begin
      result_o.stored_byte = rx_byte_i;
    end
    result_o.frame_status = status_d;
  end

  // State registers, updated on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      len_q    <= '0;
      sum_q    <= '0;
      status_q <= StReceiving;
    end else if (step_i) begin
      count_q  <= count_d;
      len_q    <= len_d;
      sum_q    <= sum_d;
      status_q <= status_d;
    end
  end

endmodule

@@ hdl/command_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// command_frame_receiver
// Parses ':'-started command frames byte by byte and reports status.
// ----------------------------------------------------------------------------
// An accepted request's result shows on out_res in the next cycle.
// Throughput: one request per cycle while out_res.ready is high or the result
//   register is empty; the frame state is a single register stage.
// Reset: rst_ni clears frame state, status (receiving), checksum enable and
//   the result valid flag.
module command_frame_receiver (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i,
  cfr_in_if.sink          in_req,
  cfr_out_if.source       out_res
);
  import cfr_pkg::*;

  logic    checksum_en_q;
  logic    accept;
  logic    out_valid_q;
  result_t result;
  result_t result_q;

  // Checksum enable register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      checksum_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      checksum_en_q <= cfg_wdata_i;
    end
  end

  // Take a request whenever the result register is empty or draining
  assign in_req.ready = !out_valid_q || out_res.ready;
  assign accept       = in_req.valid && in_req.ready;

  cfr_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (accept),
    .cmd_i         (in_req.cmd),
    .rx_byte_i     (in_req.rx_byte),
    .checksum_en_i (checksum_en_q),
    .result_o      (result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_req.ready) begin
      out_valid_q <= in_req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result;
    end
  end

  assign out_res.valid        = out_valid_q;
  assign out_res.stored       = result_q.stored;
  assign out_res.position     = result_q.position;
  assign out_res.stored_byte  = result_q.stored_byte;
  assign out_res.frame_status = result_q.frame_status;

endmodule

@@ hdl/cfr_checker.sv @@
// ----------------------------------------------------------------------------
// cfr_checker
// Port-level checks on the command frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module cfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       stored_i,
  input logic [4:0] position_i,
  input logic [7:0] stored_byte_i,
  input logic [2:0] frame_status_i
);
  import cfr_pkg::*;

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(stored_i) && $stable(position_i)
       && $stable(stored_byte_i) && $stable(frame_status_i)))
    else $error("stalled result changed");

  // Every accepted request shows a result the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> out_valid_i)
    else $error("accepted request produced no result");

  // Nothing stored means zero position and byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !stored_i) |-> (position_i == 5'd0 && stored_byte_i == 8'd0))
    else $error("unstored result carries data");

  // Position zero is always the start character while still receiving
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && stored_i && position_i == 5'd0) |->
      (stored_byte_i == StartChar && frame_status_i == StReceiving))
    else $error("bad start of frame");

  // A stored length byte respects the payload limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && stored_i && position_i == 5'd1) |->
      ({1'b0, stored_byte_i[4:0]} <= MaxLen && frame_status_i == StReceiving))
    else $error("length byte over limit stored");

endmodule

bind command_frame_receiver cfr_checker u_cfr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_req.valid),
  .in_ready_i     (in_req.ready),
  .out_valid_i    (out_res.valid),
  .out_ready_i    (out_res.ready),
  .stored_i       (out_res.stored),
  .position_i     (out_res.position),
  .stored_byte_i  (out_res.stored_byte),
  .frame_status_i (out_res.frame_status)
);
